// ===== src/pelc_pkg.sv =====
// ----------------------------------------------------------------------------
// pelc_pkg: shared types and constants of the PIN entry lock controller
// Holds the action, event and phase codes, key codes, digit store sizes and
// the structs that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package pelc_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam int MINLEN_W   = 5;
    localparam int FLASH_W    = 8;
    localparam int KEY_W      = 8;
    localparam int DIGIT_W    = 4;
    localparam int CTR_W      = 32;
    localparam int DIGOUT_W   = 5;
    localparam int CFG_W      = 8;

    localparam logic [MINLEN_W-1:0] MINLEN_RST = MINLEN_W'(4);
    localparam logic [FLASH_W-1:0]  FLASH_RST  = FLASH_W'(12);

    localparam logic [KEY_W-1:0] KEY_BS   = 8'd8;
    localparam logic [KEY_W-1:0] KEY_LF   = 8'd10;
    localparam logic [KEY_W-1:0] KEY_CR   = 8'd13;
    localparam logic [KEY_W-1:0] KEY_ZERO = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE = 8'h39;

    typedef enum logic [1:0] {
        ACT_KEY   = 2'd0,
        ACT_LOCK  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_UNLOCKED = 3'd1,
        EV_WRONG    = 3'd2,
        EV_ENROLLED = 3'd3,
        EV_BADLEN   = 3'd4,
        EV_MISMATCH = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        PH_VALIDATE = 2'd0,
        PH_PICK     = 2'd1,
        PH_CONFIRM  = 2'd2
    } phase_t;

    typedef enum logic {
        CFG_MIN_LEN = 1'b0,
        CFG_FLASH   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        action_t           action;
        logic [KEY_W-1:0]  key_code;
    } item_t;

    typedef struct packed {
        logic                locked;
        phase_t              phase;
        logic [DIGOUT_W-1:0] digits_entered;
        logic                flash_on;
        event_t              event_res;
        logic [CTR_W-1:0]    failed_count;
        logic [CTR_W-1:0]    unlock_total;
    } result_t;

endpackage

// ===== src/pelc_in_reg.sv =====
// ----------------------------------------------------------------------------
// pelc_in_reg: input word register
// Captures one word from the slave side and holds it until the core takes it.
// ----------------------------------------------------------------------------
module pelc_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pelc_pkg::item_t in_item,
    input  logic            take,
    output logic            item_valid,
    output pelc_pkg::item_t item
);
    import pelc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register frees up in the same cycle that the core consumes it.
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/pelc_core.sv =====
// ----------------------------------------------------------------------------
// pelc_core: lock state and combinational item processing
// Holds the configuration, the lock state and the three digit stores, and
// works out the next state and the result for one word combinationally.
// ----------------------------------------------------------------------------
module pelc_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  pelc_pkg::cfg_index_t          cfg_addr,
    input  logic [pelc_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          fire,
    input  pelc_pkg::item_t               item,
    output pelc_pkg::result_t             result
);
    import pelc_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    logic [MINLEN_W-1:0] min_len_reg;
    logic [FLASH_W-1:0]  flash_reload_reg;

    logic                active_reg, active_next;
    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]    first_count_reg, first_count_next;
    logic [CNT_W-1:0]    stored_count_reg, stored_count_next;
    logic [FLASH_W-1:0]  flash_reg, flash_next;
    logic [CTR_W-1:0]    failed_reg, failed_next;
    logic [CTR_W-1:0]    unlock_reg, unlock_next;

    logic [DIGIT_W-1:0]  entry_digits_reg  [MAX_DIGITS];
    logic [DIGIT_W-1:0]  first_digits_reg  [MAX_DIGITS];
    logic [DIGIT_W-1:0]  stored_digits_reg [MAX_DIGITS];

    logic                entry_wr;
    logic                copy_first;
    logic                copy_stored;
    logic                flash_on;
    event_t              ev;

    logic [DIGIT_W-1:0]  ref_digits [MAX_DIGITS];
    logic [CNT_W-1:0]    ref_count;
    logic [MAX_DIGITS-1:0] lane_diff;
    logic                match;
    logic                is_digit;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg      <= MINLEN_RST;
            flash_reload_reg <= FLASH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MIN_LEN: min_len_reg      <= cfg_wdata[MINLEN_W-1:0];
                CFG_FLASH:   flash_reload_reg <= cfg_wdata[FLASH_W-1:0];
                default:     ;
            endcase
        end
    end

    // The entry is compared with the stored PIN while validating and with the
    // picked PIN while confirming. Every lane is evaluated, so the compare
    // takes the same path whatever the digits are.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            ref_digits[i] = (phase_reg == PH_CONFIRM) ? first_digits_reg[i]
                                                      : stored_digits_reg[i];
        end
        ref_count = (phase_reg == PH_CONFIRM) ? first_count_reg : stored_count_reg;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            lane_diff[i] = (CNT_W'(i) < entry_count_reg) && (CNT_W'(i) < ref_count) &&
                           (entry_digits_reg[i] != ref_digits[i]);
        end
        match = (entry_count_reg == ref_count) && (lane_diff == '0);
    end

    assign is_digit = (item.key_code >= KEY_ZERO) && (item.key_code <= KEY_NINE);

    always_comb begin
        active_next       = active_reg;
        phase_next        = phase_reg;
        entry_count_next  = entry_count_reg;
        first_count_next  = first_count_reg;
        stored_count_next = stored_count_reg;
        flash_next        = flash_reg;
        failed_next       = failed_reg;
        unlock_next       = unlock_reg;
        entry_wr          = 1'b0;
        copy_first        = 1'b0;
        copy_stored       = 1'b0;
        flash_on          = 1'b0;
        ev                = EV_NONE;

        case (item.action)
            ACT_KEY: begin
                if (active_reg) begin
                    if (item.key_code == KEY_BS) begin
                        if (entry_count_reg != '0) begin
                            entry_count_next = entry_count_reg - 1'b1;
                        end
                    end else if (item.key_code == KEY_LF || item.key_code == KEY_CR) begin
                        if (entry_count_reg == '0) begin
                            ev = EV_NONE;
                        end else if (phase_reg != PH_VALIDATE) begin
                            if ((CNT_W + 1)'(entry_count_reg) < (CNT_W + 1)'(min_len_reg) ||
                                entry_count_reg > MAX_CNT) begin
                                flash_next       = flash_reload_reg;
                                entry_count_next = '0;
                                ev               = EV_BADLEN;
                            end else if (phase_reg == PH_PICK) begin
                                copy_first       = 1'b1;
                                first_count_next = entry_count_reg;
                                entry_count_next = '0;
                                phase_next       = PH_CONFIRM;
                            end else if (!match) begin
                                phase_next       = PH_PICK;
                                first_count_next = '0;
                                entry_count_next = '0;
                                flash_next       = flash_reload_reg;
                                ev               = EV_MISMATCH;
                            end else begin
                                copy_stored       = 1'b1;
                                stored_count_next = first_count_reg;
                                phase_next        = PH_VALIDATE;
                                unlock_next       = unlock_reg + 1'b1;
                                active_next       = 1'b0;
                                entry_count_next  = '0;
                                first_count_next  = '0;
                                flash_next        = '0;
                                ev                = EV_ENROLLED;
                            end
                        end else if (match) begin
                            unlock_next      = unlock_reg + 1'b1;
                            active_next      = 1'b0;
                            entry_count_next = '0;
                            flash_next       = '0;
                            ev               = EV_UNLOCKED;
                        end else begin
                            failed_next      = failed_reg + 1'b1;
                            flash_next       = flash_reload_reg;
                            entry_count_next = '0;
                            ev               = EV_WRONG;
                        end
                    end else if (is_digit && entry_count_reg < MAX_CNT) begin
                        entry_wr         = 1'b1;
                        entry_count_next = entry_count_reg + 1'b1;
                    end
                end
            end
            ACT_LOCK: begin
                entry_count_next = '0;
                active_next      = 1'b1;
                flash_next       = '0;
                if ((CNT_W + 1)'(stored_count_reg) < (CNT_W + 1)'(min_len_reg)) begin
                    phase_next       = PH_PICK;
                    first_count_next = '0;
                end else begin
                    phase_next = PH_VALIDATE;
                end
            end
            ACT_TICK: begin
                if (active_reg && flash_reg != '0) begin
                    flash_on   = 1'b1;
                    flash_next = flash_reg - 1'b1;
                end
            end
            ACT_CLEAR: begin
                stored_count_next = '0;
            end
            default: ;
        endcase
    end

    assign result.locked         = active_next;
    assign result.phase          = phase_next;
    assign result.digits_entered = DIGOUT_W'(entry_count_next);
    assign result.flash_on       = flash_on;
    assign result.event_res      = ev;
    assign result.failed_count   = failed_next;
    assign result.unlock_total   = unlock_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            phase_reg        <= PH_VALIDATE;
            entry_count_reg  <= '0;
            first_count_reg  <= '0;
            stored_count_reg <= '0;
            flash_reg        <= '0;
            failed_reg       <= '0;
            unlock_reg       <= '0;
        end else if (fire) begin
            active_reg       <= active_next;
            phase_reg        <= phase_next;
            entry_count_reg  <= entry_count_next;
            first_count_reg  <= first_count_next;
            stored_count_reg <= stored_count_next;
            flash_reg        <= flash_next;
            failed_reg       <= failed_next;
            unlock_reg       <= unlock_next;
        end
    end

    // Digit stores are only read below their counts, so they need no reset.
    always_ff @(posedge aclk) begin
        if (fire && entry_wr) begin
            entry_digits_reg[entry_count_reg[IDX_W-1:0]] <= item.key_code[DIGIT_W-1:0];
        end
        if (fire && copy_first) begin
            first_digits_reg <= entry_digits_reg;
        end
        if (fire && copy_stored) begin
            stored_digits_reg <= first_digits_reg;
        end
    end

    a_entry_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= MAX_CNT)
        else $error("entry count beyond the digit store");

    a_unlocked_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (entry_count_reg == '0 && phase_reg == PH_VALIDATE))
        else $error("unlocked with a pending entry or enrollment");

    a_confirm_has_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CONFIRM |-> first_count_reg != '0)
        else $error("confirm phase without a picked PIN");

    a_unlock_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (ev == EV_UNLOCKED || ev == EV_ENROLLED) |=>
            !active_reg && unlock_reg == $past(unlock_reg) + 1'b1)
        else $error("unlock did not release the lock and count");

endmodule

// ===== src/pelc_out_reg.sv =====
// ----------------------------------------------------------------------------
// pelc_out_reg: result word register
// Holds one finished result until the master side takes it.
// ----------------------------------------------------------------------------
module pelc_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  pelc_pkg::result_t result,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output pelc_pkg::result_t out_result
);
    import pelc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ===== src/pin_entry_lock_controller.sv =====
// ----------------------------------------------------------------------------
// pin_entry_lock_controller: keypad PIN lock with PIN enrollment
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  tuser: action, tdata: key_code
//   m_        out        m_tvalid/m_tready  tdata: lock status and counters
//   cfg_      in         cfg_wr_en          cfg_addr selects, cfg_wdata value
//
// One word is accepted per cycle when the master side keeps taking results.
// A result is presented only after its word is accepted and registered: the word sits in
// the input register, then the core updates the state and loads the result register.
// Reset is synchronous and active low; digit stores are not cleared.
// A stall on the master side holds the result register and lets one more word
// wait in the input register before s_tready drops.
// ----------------------------------------------------------------------------
module pin_entry_lock_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_code
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] locked, [2:1] phase, [7:3] digits_entered, [8] flash_on,
    // [11:9] event_res, [43:12] failed_count, [75:44] unlock_total, [79:76] zero
    output logic [79:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import pelc_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    fire;
    result_t result;
    result_t out_result;

    assign in_item.action   = action_t'(s_tuser);
    assign in_item.key_code = s_tdata;

    // A word is processed when it sits in the input register and the result
    // register is free or being emptied.
    assign fire = item_valid && can_load;

    pelc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    pelc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_index_t'(cfg_addr)),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    pelc_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .result     (result),
        .can_load   (can_load),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {4'b0000,
                      out_result.unlock_total,
                      out_result.failed_count,
                      out_result.event_res,
                      out_result.flash_on,
                      out_result.digits_entered,
                      out_result.phase,
                      out_result.locked};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the PIN entry lock controller
// Drives key, lock, tick and clear words into the block with random gaps
// while an internal lock model predicts every result word. The master side
// stalls at random and the stream is split into phases with different
// minimum PIN lengths and flash reloads, written while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import pelc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] pin_digits_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    // Lock model state and its copy of the registers.
    logic        lk_active;
    phase_t      lk_phase;
    pin_digits_t ent_dig, fst_dig, sto_dig;
    int          ent_cnt, fst_cnt, sto_cnt;
    logic [7:0]  flash_left;
    logic [31:0] fail_ctr, unlock_ctr;
    logic [4:0]  min_len_reg;
    logic [7:0]  flash_reload_reg;

    item_t       key_words_q[$];
    result_t     status_q[$];
    int          word_cnt     = 0;
    int          fail_cnt     = 0;
    int          cycle_cnt    = 0;
    int          tx_gap       = 0;
    int          rx_stall     = 0;
    int          rx_hold_left = 0;
    bit          tx_idle_en   = 1'b1;
    bit          rx_idle_en   = 1'b1;
    item_t       tx_word;

    // PINs the stimulus keeps reusing so that unlocks and confirms succeed.
    pin_digits_t pool_d [2];
    int          pool_n [2];

    int min_tab   [PHASES] = '{4, 1, 16, 0, 20, 6, 3, 2};
    int flash_tab [PHASES] = '{12, 0, 255, 5, 1, 2, 200, 3};

    pin_entry_lock_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Full-length compare: equal counts and equal digits below the count.
    function automatic bit same_pin(input pin_digits_t a, input int na,
                                    input pin_digits_t b, input int nb);
        bit eq;
        eq = (na == nb);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (i < na && i < nb && a[i] != b[i])
                eq = 1'b0;
        end
        return eq;
    endfunction

    function automatic result_t lock_step(input item_t it);
        result_t r;
        event_t  ev;
        logic    show;
        ev   = EV_NONE;
        show = 1'b0;
        case (it.action)
            ACT_KEY: begin
                if (lk_active) begin
                    if (it.key_code == KEY_BS) begin
                        if (ent_cnt > 0)
                            ent_cnt--;
                    end else if (it.key_code == KEY_LF || it.key_code == KEY_CR) begin
                        if (ent_cnt != 0) begin
                            if (lk_phase != PH_VALIDATE) begin
                                if (ent_cnt < min_len_reg || ent_cnt > MAX_DIGITS) begin
                                    flash_left = flash_reload_reg;
                                    ent_cnt    = 0;
                                    ev         = EV_BADLEN;
                                end else if (lk_phase == PH_PICK) begin
                                    fst_dig  = ent_dig;
                                    fst_cnt  = ent_cnt;
                                    ent_cnt  = 0;
                                    lk_phase = PH_CONFIRM;
                                end else if (!same_pin(ent_dig, ent_cnt, fst_dig, fst_cnt)) begin
                                    lk_phase   = PH_PICK;
                                    fst_cnt    = 0;
                                    ent_cnt    = 0;
                                    flash_left = flash_reload_reg;
                                    ev         = EV_MISMATCH;
                                end else begin
                                    sto_dig    = fst_dig;
                                    sto_cnt    = fst_cnt;
                                    lk_phase   = PH_VALIDATE;
                                    unlock_ctr = unlock_ctr + 1;
                                    lk_active  = 1'b0;
                                    ent_cnt    = 0;
                                    fst_cnt    = 0;
                                    flash_left = '0;
                                    ev         = EV_ENROLLED;
                                end
                            end else if (same_pin(ent_dig, ent_cnt, sto_dig, sto_cnt)) begin
                                unlock_ctr = unlock_ctr + 1;
                                lk_active  = 1'b0;
                                ent_cnt    = 0;
                                flash_left = '0;
                                ev         = EV_UNLOCKED;
                            end else begin
                                fail_ctr   = fail_ctr + 1;
                                flash_left = flash_reload_reg;
                                ent_cnt    = 0;
                                ev         = EV_WRONG;
                            end
                        end
                    end else if (it.key_code >= KEY_ZERO && it.key_code <= KEY_NINE &&
                                 ent_cnt < MAX_DIGITS) begin
                        ent_dig[ent_cnt] = DIGIT_W'(it.key_code - KEY_ZERO);
                        ent_cnt++;
                    end
                end
            end
            ACT_LOCK: begin
                ent_cnt    = 0;
                lk_active  = 1'b1;
                flash_left = '0;
                if (sto_cnt < min_len_reg) begin
                    lk_phase = PH_PICK;
                    fst_cnt  = 0;
                end else begin
                    lk_phase = PH_VALIDATE;
                end
            end
            ACT_TICK: begin
                if (lk_active && flash_left != 0) begin
                    show = 1'b1;
                    flash_left--;
                end
            end
            default: begin
                sto_cnt = 0;
            end
        endcase
        r.locked         = lk_active;
        r.phase          = lk_phase;
        r.digits_entered = DIGOUT_W'(ent_cnt);
        r.flash_on       = show;
        r.event_res      = ev;
        r.failed_count   = fail_ctr;
        r.unlock_total   = unlock_ctr;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Driver: a word is predicted at the edge where it is accepted.
    always @(posedge aclk) begin : drv
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                status_q.push_back(lock_step(tx_word));
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (key_words_q.size() != 0) begin
                    tx_word = key_words_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_word.key_code;
                    s_tuser  <= tx_word.action;
                    if (tx_idle_en && $urandom_range(0, 99) < 30)
                        tx_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction.
    always @(posedge aclk) begin : mon
        result_t want;
        bit      bad;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result word %h", m_tdata);
                end else begin
                    want = status_q.pop_front();
                    bad  = m_tdata[0] !== want.locked ||
                           m_tdata[2:1] !== want.phase ||
                           m_tdata[7:3] !== want.digits_entered ||
                           m_tdata[8] !== want.flash_on ||
                           m_tdata[11:9] !== want.event_res ||
                           m_tdata[43:12] !== want.failed_count ||
                           m_tdata[75:44] !== want.unlock_total;
                    if (bad) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("mismatch exp: locked %0d phase %0d digits %0d flash %0d %s",
                                     want.locked, want.phase, want.digits_entered,
                                     want.flash_on, "");
                            $display("  exp: event %0d failed %0d unlocks %0d",
                                     want.event_res, want.failed_count, want.unlock_total);
                            $display("  got: locked %0d phase %0d digits %0d flash %0d",
                                     m_tdata[0], m_tdata[2:1], m_tdata[7:3], m_tdata[8]);
                            $display("  got: event %0d failed %0d unlocks %0d",
                                     m_tdata[11:9], m_tdata[43:12], m_tdata[75:44]);
                        end
                    end
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
                rx_stall = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_item(input action_t act, input logic [7:0] key);
        item_t it;
        it.action   = act;
        it.key_code = key;
        key_words_q.push_back(it);
        word_cnt++;
    endtask

    task automatic push_digits(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(ACT_KEY, s[i]);
    endtask

    task automatic push_enter();
        push_item(ACT_KEY, ($urandom_range(0, 1) != 0) ? KEY_LF : KEY_CR);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MIN_LEN)
            min_len_reg = val[4:0];
        else
            flash_reload_reg = val;
    endtask

    // Every word gives one result, so an empty prediction queue means idle.
    task automatic wait_idle();
        while (key_words_q.size() != 0 || s_tvalid || status_q.size() != 0)
            @(negedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic new_pin(input int slot);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            pool_n[slot] = int'(min_len_reg) + $urandom_range(0, 2);
        else if (r < 9)
            pool_n[slot] = $urandom_range(1, MAX_DIGITS);
        else
            pool_n[slot] = $urandom_range(MAX_DIGITS, MAX_DIGITS + 2);
        if (pool_n[slot] < 1)
            pool_n[slot] = 1;
        if (r < 7 && pool_n[slot] > MAX_DIGITS)
            pool_n[slot] = MAX_DIGITS;
        for (int i = 0; i < MAX_DIGITS; i++)
            pool_d[slot][i] = DIGIT_W'($urandom_range(0, 9));
    endtask

    // Types a pooled PIN; digits past the store size are typed at random.
    task automatic type_pin(input int slot, input bit mutate);
        logic [3:0] dg;
        int         bad_at;
        bad_at = mutate ? $urandom_range(0, pool_n[slot] - 1) : -1;
        for (int i = 0; i < pool_n[slot]; i++) begin
            dg = (i < MAX_DIGITS) ? pool_d[slot][i] : DIGIT_W'($urandom_range(0, 9));
            if (i == bad_at)
                dg = DIGIT_W'((dg + 1) % 10);
            if ($urandom_range(0, 19) == 0) begin
                push_item(ACT_KEY, 8'(KEY_ZERO + $urandom_range(0, 9)));
                push_item(ACT_KEY, KEY_BS);
            end
            push_item(ACT_KEY, 8'(KEY_ZERO + dg));
        end
    endtask

    task automatic run_phase(input int n);
        int start, r, k;
        start = word_cnt;
        new_pin(0);
        new_pin(1);
        while (word_cnt - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                push_item(ACT_LOCK, 8'($urandom_range(0, 255)));
            end else if (r < 45) begin
                type_pin($urandom_range(0, 1), $urandom_range(0, 6) == 0);
                push_enter();
            end else if (r < 60) begin
                // Enrollment attempt: lock, then pick and confirm if the lock asks for a new PIN.
                push_item(ACT_LOCK, 8'h00);
                if ($urandom_range(0, 1) != 0)
                    new_pin(0);
                type_pin(0, 1'b0);
                push_enter();
                type_pin(0, $urandom_range(0, 4) == 0);
                push_enter();
            end else if (r < 72) begin
                k = $urandom_range(1, 5);
                repeat (k) push_item(ACT_TICK, 8'($urandom_range(0, 255)));
            end else if (r < 76) begin
                push_item(ACT_CLEAR, 8'($urandom_range(0, 255)));
            end else if (r < 90) begin
                push_item(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                type_pin($urandom_range(0, 1), 1'b0);
                k = $urandom_range(1, 4);
                repeat (k) push_item(ACT_KEY, KEY_BS);
                push_enter();
            end
        end
    endtask

    initial begin : stim
        int m;
        lk_active        = 1'b0;
        lk_phase         = PH_VALIDATE;
        ent_dig          = '0;
        fst_dig          = '0;
        sto_dig          = '0;
        ent_cnt          = 0;
        fst_cnt          = 0;
        sto_cnt          = 0;
        flash_left       = '0;
        fail_ctr         = '0;
        unlock_ctr       = '0;
        min_len_reg      = MINLEN_RST;
        flash_reload_reg = FLASH_RST;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(CFG_MIN_LEN, 8'd2);
        write_reg(CFG_FLASH, 8'd3);
        @(negedge aclk);

        // Directed walk through the lock: unlocked keys, empty entry, bad
        // length, pick, confirm mismatch, enrollment, wrong PIN, clear.
        push_item(ACT_TICK, 8'h00);
        push_digits("5");
        push_item(ACT_LOCK, 8'hFF);
        push_item(ACT_KEY, KEY_LF);
        push_item(ACT_KEY, KEY_BS);
        push_item(ACT_KEY, 8'hFF);
        push_digits("1");
        push_item(ACT_KEY, KEY_LF);
        push_item(ACT_TICK, 8'h00);
        push_digits("90");
        push_item(ACT_KEY, KEY_LF);
        push_digits("91");
        push_item(ACT_KEY, KEY_CR);
        push_digits("90");
        push_item(ACT_KEY, KEY_LF);
        push_digits("90");
        push_item(ACT_KEY, KEY_CR);
        push_item(ACT_LOCK, 8'h00);
        push_digits("91");
        push_item(ACT_KEY, KEY_LF);
        push_item(ACT_CLEAR, 8'h00);
        push_digits("90");
        push_item(ACT_KEY, KEY_CR);
        push_item(ACT_LOCK, 8'h00);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            m = (ph == 6) ? $urandom_range(1, 8) : min_tab[ph];
            write_reg(CFG_MIN_LEN, 8'(m));
            write_reg(CFG_FLASH, 8'(flash_tab[ph]));
            @(negedge aclk);
            tx_idle_en = (ph != 2);
            rx_idle_en = (ph != 2);
            // Hold the result side off while words keep coming, so the
            // block backs up and drops s_tready.
            if (ph == 0 || ph == 5)
                rx_hold_left = $urandom_range(200, 300);
            run_phase(56);
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/pelc_pkg.sv
src/pelc_in_reg.sv
src/pelc_core.sv
src/pelc_out_reg.sv
src/pin_entry_lock_controller.sv
tb/tb.sv
